// ===== rtl/core/cc3_pkg.sv =====
// ----------------------------------------------------------------------------
// cc3_pkg: shared constants and types for the 3-bit coefficient compressor
// Modulus, polynomial length, reciprocal for reduction, code rounding helper.
// ----------------------------------------------------------------------------
package cc3_pkg;

  localparam int unsigned MODULUS     = 7681;
  localparam int unsigned POLY_LENGTH = 512;

  localparam int unsigned COEFF_W = 16;
  localparam int unsigned CODE_W  = 3;
  localparam int unsigned BYTE_W  = 8;

  localparam int unsigned MOD_W  = $clog2(MODULUS + 1);
  localparam int unsigned CNT_W  = $clog2(POLY_LENGTH);
  localparam int unsigned HCNT_W = $clog2(BYTE_W);
  localparam int unsigned ACC_W  = BYTE_W + CODE_W;
  localparam int unsigned TOT_W  = HCNT_W + 1;

  localparam int unsigned RECIP_SHIFT = 32;
  localparam int unsigned RECIP_W     = 32;
  localparam int unsigned QHAT_W      = COEFF_W;
  localparam int unsigned PROD_W      = COEFF_W + RECIP_W;
  localparam longint unsigned RecipL  = (64'd1 << RECIP_SHIFT) / MODULUS;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RecipL);

  localparam int unsigned SCALED_W = MOD_W + CODE_W;
  localparam int unsigned LEVELS   = 1 << CODE_W;

  typedef struct packed {
    logic              valid;
    logic [CODE_W-1:0] code;
  } code_xfer_t;

  function automatic logic [CODE_W-1:0] code_of(input logic [MOD_W-1:0] r);
    logic [SCALED_W-1:0] r8;
    logic [CODE_W:0]     n;
    r8 = SCALED_W'(r) << CODE_W;
    n  = '0;
    for (int k = 1; k <= int'(LEVELS); k++) begin
      if (r8 >= SCALED_W'(k * int'(MODULUS) - int'(MODULUS / 2))) begin
        n = n + 1'b1;
      end
    end
    return n[CODE_W-1:0];
  endfunction

endpackage

// ===== rtl/core/cc3_reduce.sv =====
// ----------------------------------------------------------------------------
// cc3_reduce: modular reduction and 3-bit rounding pipeline
// Reciprocal quotient, remainder with one correction, then rounded code.
// ----------------------------------------------------------------------------
module cc3_reduce
  import cc3_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COEFF_W-1:0] coefficient_i,
  output code_xfer_t         code_o,
  input  logic               code_ready_i
);

  logic               s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  logic               s1_ready, s2_ready, s3_ready, s4_ready;
  logic [COEFF_W-1:0] s1_coeff_q, s2_coeff_q;
  logic [QHAT_W-1:0]  s2_qhat_q;
  logic [MOD_W-1:0]   s3_rem_q;
  logic [CODE_W-1:0]  s4_code_q;

  logic [PROD_W-1:0]  prod;
  logic [COEFF_W-1:0] qm;
  logic [COEFF_W-1:0] rem_raw;
  logic [COEFF_W-1:0] rem_fix;

  assign s4_ready = !s4_valid_q || code_ready_i;
  assign s3_ready = !s3_valid_q || s4_ready;
  assign s2_ready = !s2_valid_q || s3_ready;
  assign s1_ready = !s1_valid_q || s2_ready;
  assign in_ready_o = s1_ready;

  assign prod    = PROD_W'(s1_coeff_q) * PROD_W'(RECIP);
  assign qm      = COEFF_W'(s2_qhat_q * COEFF_W'(MODULUS));
  assign rem_raw = s2_coeff_q - qm;
  assign rem_fix = (rem_raw >= COEFF_W'(MODULUS)) ? rem_raw - COEFF_W'(MODULUS) : rem_raw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else begin
      if (s1_ready) s1_valid_q <= in_valid_i;
      if (s2_ready) s2_valid_q <= s1_valid_q;
      if (s3_ready) s3_valid_q <= s2_valid_q;
      if (s4_ready) s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_coeff_q <= coefficient_i;
    end
    if (s2_ready && s1_valid_q) begin
      s2_coeff_q <= s1_coeff_q;
      s2_qhat_q  <= prod[RECIP_SHIFT +: QHAT_W];
    end
    if (s3_ready && s2_valid_q) begin
      s3_rem_q <= rem_fix[MOD_W-1:0];
    end
    if (s4_ready && s3_valid_q) begin
      s4_code_q <= code_of(s3_rem_q);
    end
  end

  assign code_o.valid = s4_valid_q;
  assign code_o.code  = s4_code_q;

endmodule

// ===== rtl/core/cc3_pack.sv =====
// ----------------------------------------------------------------------------
// cc3_pack: LSB-first byte packer for 3-bit codes
// Gathers codes, emits a byte per eight bits, flags the last polynomial byte.
// ----------------------------------------------------------------------------
module cc3_pack
  import cc3_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  code_xfer_t        code_i,
  output logic              code_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] packed_byte_o,
  output logic              last_o
);

  logic [BYTE_W-1:0] hold_q, hold_d;
  logic [HCNT_W-1:0] hcnt_q, hcnt_d;
  logic [CNT_W-1:0]  ccnt_q, ccnt_d;
  logic              out_valid_q, out_valid_d;
  logic [BYTE_W-1:0] byte_q, byte_d;
  logic              last_q, last_d;

  logic              take;
  logic [ACC_W-1:0]  acc;
  logic [TOT_W-1:0]  total;
  logic              is_last;

  assign code_ready_o = !out_valid_q || out_ready_i;
  assign take         = code_i.valid && code_ready_o;

  assign acc     = ACC_W'(hold_q) | (ACC_W'(code_i.code) << hcnt_q);
  assign total   = TOT_W'(hcnt_q) + TOT_W'(CODE_W);
  assign is_last = (ccnt_q == CNT_W'(POLY_LENGTH - 1));

  always_comb begin
    hold_d      = hold_q;
    hcnt_d      = hcnt_q;
    ccnt_d      = ccnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    byte_d      = byte_q;
    last_d      = last_q;
    if (take) begin
      byte_d = acc[BYTE_W-1:0];
      priority if (is_last) begin
        out_valid_d = 1'b1;
        last_d      = 1'b1;
        hold_d      = '0;
        hcnt_d      = '0;
        ccnt_d      = '0;
      end else if (total >= TOT_W'(BYTE_W)) begin
        out_valid_d = 1'b1;
        last_d      = 1'b0;
        hold_d      = BYTE_W'(acc >> BYTE_W);
        hcnt_d      = HCNT_W'(total - TOT_W'(BYTE_W));
        ccnt_d      = ccnt_q + 1'b1;
      end else begin
        hold_d = acc[BYTE_W-1:0];
        hcnt_d = total[HCNT_W-1:0];
        ccnt_d = ccnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_q      <= '0;
      hcnt_q      <= '0;
      ccnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hold_q      <= hold_d;
      hcnt_q      <= hcnt_d;
      ccnt_q      <= ccnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      byte_q <= byte_d;
      last_q <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign packed_byte_o = byte_q;
  assign last_o        = last_q;

endmodule

// ===== rtl/core/coefficient_compress_3bit.sv =====
// ----------------------------------------------------------------------------
// coefficient_compress_3bit: coefficient reduce, 3-bit round, byte pack
// Takes one coefficient per cycle while out_ready_i does not stall the output.
// Four reduce stages and the packer's output register lie between input and byte.
// Reset clears all valid flags, the gathered bits and both counters.
// ----------------------------------------------------------------------------
module coefficient_compress_3bit
  import cc3_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [COEFF_W-1:0] coefficient_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BYTE_W-1:0]  packed_byte_o,
  output logic               last_o
);

  code_xfer_t code;
  logic       code_ready;

  cc3_reduce u_reduce (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .coefficient_i (coefficient_i),
    .code_o        (code),
    .code_ready_i  (code_ready)
  );

  cc3_pack u_pack (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .code_i        (code),
    .code_ready_o  (code_ready),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .last_o        (last_o)
  );

endmodule

// ===== tb/sv/coefficient_compress_3bit_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coefficient_compress_3bit_tb: self-checking bench for the 3-bit compressor
// Streams about 900 coefficients through the block: one whole polynomial and
// most of a second. The first part is directed: field extremes, modulus
// multiples and rounding edges. The rest is random. Both handshakes stall at
// random. Each byte is checked against a predicted reduce, round and
// LSB-first pack of the codes.
// ----------------------------------------------------------------------------
module coefficient_compress_3bit_tb;
  import cc3_pkg::*;

  localparam int unsigned NUM_ITEMS = 900;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_out_t;

  logic               clk_i;
  logic               rst_ni        = 1'b0;
  logic               in_valid_i    = 1'b0;
  logic               in_ready_o;
  logic [COEFF_W-1:0] coefficient_i = '0;
  logic               out_valid_o;
  logic               out_ready_i   = 1'b0;
  logic [BYTE_W-1:0]  packed_byte_o;
  logic               last_o;

  logic [COEFF_W-1:0] coeff_pending_q[$];
  packed_out_t        byte_expect_q[$];

  logic [BYTE_W-1:0]  pack_bits;
  int unsigned        pack_fill;
  int unsigned        coeff_index;

  int unsigned        total_items;
  int unsigned        accepted_cnt;
  int unsigned        byte_cnt;
  int unsigned        end_cnt;
  int unsigned        error_cnt;
  bit                 calm;

  coefficient_compress_3bit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .coefficient_i (coefficient_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .packed_byte_o (packed_byte_o),
    .last_o        (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  task automatic report_mismatch(input string what, input int unsigned want,
                                 input int unsigned got);
    $display("mismatch at byte %0d: %s expected 0x%0h got 0x%0h",
             byte_cnt, what, want, got);
    error_cnt++;
  endtask

  function automatic logic [CODE_W-1:0] round_code(input logic [COEFF_W-1:0] c);
    int unsigned r;
    int unsigned q;
    r = int'(c) % MODULUS;
    q = ((r << CODE_W) + MODULUS / 2) / MODULUS;
    return CODE_W'(q);
  endfunction

  task automatic compress_and_pack(input logic [COEFF_W-1:0] c);
    logic [ACC_W-1:0] acc;
    int unsigned      total;
    packed_out_t      item;
    acc   = ACC_W'(pack_bits) | (ACC_W'(round_code(c)) << pack_fill);
    total = pack_fill + CODE_W;
    if (coeff_index + 1 >= POLY_LENGTH) begin
      item.data = acc[BYTE_W-1:0];
      item.last = 1'b1;
      byte_expect_q.push_back(item);
      pack_bits   = '0;
      pack_fill   = 0;
      coeff_index = 0;
    end else begin
      coeff_index++;
      if (total >= BYTE_W) begin
        item.data = acc[BYTE_W-1:0];
        item.last = 1'b0;
        byte_expect_q.push_back(item);
        pack_bits = BYTE_W'(acc >> BYTE_W);
        pack_fill = total - BYTE_W;
      end else begin
        pack_bits = acc[BYTE_W-1:0];
        pack_fill = total;
      end
    end
  endtask

  // rounding edge: smallest remainder that reaches quotient k, nudged by -1..+1
  function automatic logic [COEFF_W-1:0] rounding_edge(input int unsigned k,
                                                       input int signed nudge,
                                                       input int unsigned wrap);
    int signed r;
    int unsigned v;
    r = int'((k * MODULUS - MODULUS / 2 + 7) / 8) + nudge;
    if (r < 0) r = 0;
    if (r > int'(MODULUS) - 1) r = int'(MODULUS) - 1;
    v = int'(r) + wrap * MODULUS;
    return COEFF_W'(v);
  endfunction

  assign calm = (accepted_cnt >= 400) && (accepted_cnt < 600);

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      coefficient_i <= '0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        compress_and_pack(coefficient_i);
        accepted_cnt++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (coeff_pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 15)) begin
          in_valid_i    <= 1'b1;
          coefficient_i <= coeff_pending_q.pop_front();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (byte_expect_q.size() == 0) begin
          report_mismatch("unexpected transfer, byte", 0, packed_byte_o);
        end else begin
          packed_out_t want;
          want = byte_expect_q.pop_front();
          if (packed_byte_o !== want.data) report_mismatch("byte", want.data, packed_byte_o);
          if (last_o !== want.last) report_mismatch("last", want.last, last_o);
          if (want.last) end_cnt++;
        end
        byte_cnt++;
      end
      out_ready_i <= calm || ($urandom_range(0, 99) >= 15);
    end
  end

  initial begin
    int unsigned k;
    pack_bits    = '0;
    pack_fill    = 0;
    coeff_index  = 0;
    accepted_cnt = 0;
    byte_cnt     = 0;
    end_cnt      = 0;
    error_cnt    = 0;

    coeff_pending_q.push_back(16'h0000);
    coeff_pending_q.push_back(16'hFFFF);
    coeff_pending_q.push_back(16'h5555);
    coeff_pending_q.push_back(16'hAAAA);
    coeff_pending_q.push_back(COEFF_W'(MODULUS - 1));
    coeff_pending_q.push_back(COEFF_W'(MODULUS));
    coeff_pending_q.push_back(COEFF_W'(MODULUS + 1));
    coeff_pending_q.push_back(COEFF_W'(2 * MODULUS - 1));
    coeff_pending_q.push_back(COEFF_W'((65535 / MODULUS) * MODULUS));
    coeff_pending_q.push_back(COEFF_W'((65535 / MODULUS) * MODULUS - 1));
    for (k = 1; k <= 8; k++) begin
      coeff_pending_q.push_back(rounding_edge(k, -1, 0));
      coeff_pending_q.push_back(rounding_edge(k, 0, k % 4));
    end
    while (coeff_pending_q.size() < 26) coeff_pending_q.push_back(16'h0001);

    // one whole polynomial, then most of a second
    while (coeff_pending_q.size() < NUM_ITEMS) begin
      case ($urandom_range(0, 3))
        0, 1: coeff_pending_q.push_back(COEFF_W'($urandom));
        2: coeff_pending_q.push_back(rounding_edge($urandom_range(1, 8),
                                                   int'($urandom_range(0, 2)) - 1,
                                                   $urandom_range(0, 7)));
        default: coeff_pending_q.push_back(COEFF_W'(MODULUS * $urandom_range(0, 8)
                                                    + $urandom_range(0, 2)));
      endcase
    end
    total_items = coeff_pending_q.size();

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (accepted_cnt < total_items || byte_expect_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("covered %0d coefficients, %0d bytes checked, %0d polynomial ends",
             accepted_cnt, byte_cnt, end_cnt);
    if (error_cnt == 0) begin
      $display("coefficient_compress_3bit_tb: clean");
    end else begin
      $display("%0d mismatches", error_cnt);
      $display("coefficient_compress_3bit_tb: errors");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("timeout after %0d of %0d coefficients", accepted_cnt, total_items);
    $display("coefficient_compress_3bit_tb: errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/cc3_pkg.sv
rtl/core/cc3_reduce.sv
rtl/core/cc3_pack.sv
rtl/core/coefficient_compress_3bit.sv
tb/sv/coefficient_compress_3bit_tb.sv
